@@ rtl/stq_pkg.sv @@
// ----------------------------------------------------------------------------
// SPI transfer queue package
// Sizes, codes, word types and index helpers shared by the queue logic.
// ----------------------------------------------------------------------------
package stq_pkg;

  localparam int QUEUE_LEN = 8;
  localparam int DATA_LEN  = 16;
  localparam int CHIPS     = 4;

  localparam int SLOT_W = $clog2(QUEUE_LEN);
  localparam int IDX_W  = SLOT_W + 1;
  localparam int POS_W  = (DATA_LEN > 1) ? $clog2(DATA_LEN) : 1;
  localparam int CNT_W  = $clog2(DATA_LEN + 1);
  localparam int ADDR_W = $clog2(QUEUE_LEN * DATA_LEN);
  localparam int DEPTH  = QUEUE_LEN * DATA_LEN;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_READY = 2'd1,
    ACT_RECV  = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_LONG    = 2'd2,
    STAT_RX_IDLE = 2'd3
  } stat_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_START,
    FSM_SEND,
    FSM_REPLY
  } fsm_t;

  typedef struct packed {
    action_t    action;
    logic [1:0] chip;
    logic [7:0] data_byte;
    logic       last;
    logic       want_reply;
  } in_word_t;

  typedef struct packed {
    stat_t      status;
    logic       select_valid;
    logic [1:0] select_chip;
    logic       send_valid;
    logic [7:0] send_byte;
    logic       release_valid;
    logic       reply_valid;
    logic [7:0] reply_byte;
    logic       reply_last;
  } out_word_t;

  typedef struct packed {
    logic             reply;
    logic [1:0]       chip;
    logic [POS_W-1:0] len_m1;
  } slot_info_t;

  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx);
    return (idx == IDX_W'(2 * QUEUE_LEN - 1)) ? '0 : idx + IDX_W'(1);
  endfunction

  function automatic logic [SLOT_W-1:0] idx_slot(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] s;
    s = (idx >= IDX_W'(QUEUE_LEN)) ? idx - IDX_W'(QUEUE_LEN) : idx;
    return s[SLOT_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] byte_addr(input logic [SLOT_W-1:0] slot,
                                                  input logic [POS_W-1:0]  pos);
    return ADDR_W'(slot) * ADDR_W'(DATA_LEN) + ADDR_W'(pos);
  endfunction

  function automatic logic [1:0] chip_wrap(input logic [1:0] c);
    logic [3:0] v;
    v = {2'b00, c};
    for (int i = 0; i < 3; i++) begin
      if (v >= 4'(CHIPS)) begin
        v = v - 4'(CHIPS);
      end
    end
    return v[1:0];
  endfunction

endpackage

@@ rtl/spi_transfer_queue.sv @@
// ----------------------------------------------------------------------------
// SPI transfer queue
// Ring of transfer slots in a byte memory and a slot info memory; loads,
// starts, sends and completes SPI transfers one command word at a time.
// ----------------------------------------------------------------------------
//  channel  ports                  handshake
//  command  start, busy, in_word   taken when start high and busy low
//  result   out_valid, out_word    one-cycle strobe, never stalled
//
//  Load, idle ready, unused codes and receives that start no reply: result next.
//  Ready that sends a byte: a START or SEND state waits on the registered memory read.
//  Completion with reply: REPLY state, one byte memory read per cycle.
//  Reset (rst_n low, synchronous) empties the queue; no clearing pass.
//  The result side cannot stall; each result shows for one cycle.
module spi_transfer_queue
  import stq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_word_t  in_word,
  output logic      out_valid,
  output out_word_t out_word
);

  fsm_t             st_r, st_nxt;
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [IDX_W-1:0] tail_r, tail_nxt;
  logic             xfer_busy_r, xfer_busy_nxt;
  logic [SLOT_W-1:0] act_slot_r, act_slot_nxt;
  logic [CNT_W-1:0] act_len_r, act_len_nxt;
  logic [1:0]       act_chip_r, act_chip_nxt;
  logic             act_reply_r, act_reply_nxt;
  logic [CNT_W-1:0] sent_r, sent_nxt;
  logic [CNT_W-1:0] rcvd_r, rcvd_nxt;
  logic [CNT_W-1:0] load_cnt_r, load_cnt_nxt;
  stat_t            load_fault_r, load_fault_nxt;
  logic [CNT_W-1:0] rpl_cnt_r, rpl_cnt_nxt;
  logic             rpl_pend_r, rpl_pend_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_word_t        out_word_r, out_nxt;

  logic [7:0]        byte_mem [DEPTH];
  slot_info_t        info_mem [QUEUE_LEN];
  logic [7:0]        byte_rd_r;
  slot_info_t        info_rd_r;
  logic              byte_we, info_we;
  logic [ADDR_W-1:0] byte_waddr, byte_raddr;
  logic [7:0]        byte_wdata;
  logic [SLOT_W-1:0] info_waddr, info_raddr;
  slot_info_t        info_wdata;

  logic [IDX_W-1:0]  wait_cnt;
  logic [SLOT_W-1:0] head_slot, tail_slot;

  assign wait_cnt  = (tail_r >= head_r) ? tail_r - head_r
                                        : tail_r + IDX_W'(2 * QUEUE_LEN) - head_r;
  assign head_slot = idx_slot(head_r);
  assign tail_slot = idx_slot(tail_r);
  assign busy      = (st_r != FSM_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  always_ff @(posedge clk) begin
    byte_rd_r <= byte_mem[byte_raddr];
    info_rd_r <= info_mem[info_raddr];
    if (byte_we) begin
      byte_mem[byte_waddr] <= byte_wdata;
    end
    if (info_we) begin
      info_mem[info_waddr] <= info_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= FSM_IDLE;
      head_r       <= '0;
      tail_r       <= '0;
      xfer_busy_r  <= 1'b0;
      act_slot_r   <= '0;
      act_len_r    <= '0;
      act_chip_r   <= '0;
      act_reply_r  <= 1'b0;
      sent_r       <= '0;
      rcvd_r       <= '0;
      load_cnt_r   <= '0;
      load_fault_r <= STAT_OK;
      rpl_cnt_r    <= '0;
      rpl_pend_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      st_r         <= st_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      xfer_busy_r  <= xfer_busy_nxt;
      act_slot_r   <= act_slot_nxt;
      act_len_r    <= act_len_nxt;
      act_chip_r   <= act_chip_nxt;
      act_reply_r  <= act_reply_nxt;
      sent_r       <= sent_nxt;
      rcvd_r       <= rcvd_nxt;
      load_cnt_r   <= load_cnt_nxt;
      load_fault_r <= load_fault_nxt;
      rpl_cnt_r    <= rpl_cnt_nxt;
      rpl_pend_r   <= rpl_pend_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_nxt;
  end

  always_comb begin
    stat_t            fault;
    logic [CNT_W-1:0] rcvd_inc;

    st_nxt         = st_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    xfer_busy_nxt  = xfer_busy_r;
    act_slot_nxt   = act_slot_r;
    act_len_nxt    = act_len_r;
    act_chip_nxt   = act_chip_r;
    act_reply_nxt  = act_reply_r;
    sent_nxt       = sent_r;
    rcvd_nxt       = rcvd_r;
    load_cnt_nxt   = load_cnt_r;
    load_fault_nxt = load_fault_r;
    rpl_cnt_nxt    = rpl_cnt_r;
    rpl_pend_nxt   = rpl_pend_r;
    out_valid_nxt  = 1'b0;
    out_nxt        = '0;
    out_nxt.status = STAT_OK;

    byte_we           = 1'b0;
    byte_waddr        = byte_addr(tail_slot, load_cnt_r[POS_W-1:0]);
    byte_wdata        = in_word.data_byte;
    byte_raddr        = byte_addr(act_slot_r, sent_r[POS_W-1:0]);
    info_we           = 1'b0;
    info_waddr        = tail_slot;
    info_wdata.reply  = in_word.want_reply;
    info_wdata.chip   = chip_wrap(in_word.chip);
    info_wdata.len_m1 = load_cnt_r[POS_W-1:0];
    info_raddr        = head_slot;

    fault    = load_fault_r;
    rcvd_inc = rcvd_r;

    unique case (st_r)
      FSM_IDLE: begin
        if (start) begin
          unique case (in_word.action)
            ACT_LOAD: begin
              if (load_cnt_r == '0 && fault == STAT_OK &&
                  wait_cnt >= IDX_W'(QUEUE_LEN - 2)) begin
                fault = STAT_FULL;
              end
              if (fault == STAT_OK) begin
                if (load_cnt_r >= CNT_W'(DATA_LEN)) begin
                  fault = STAT_LONG;
                end else begin
                  byte_we      = 1'b1;
                  load_cnt_nxt = load_cnt_r + CNT_W'(1);
                end
              end
              load_fault_nxt = fault;
              out_valid_nxt  = 1'b1;
              out_nxt.status = fault;
              if (in_word.last) begin
                if (fault == STAT_OK) begin
                  info_we  = 1'b1;
                  tail_nxt = idx_inc(tail_r);
                end
                load_cnt_nxt   = '0;
                load_fault_nxt = STAT_OK;
              end
            end
            ACT_READY: begin
              if (!xfer_busy_r && wait_cnt != '0) begin
                head_nxt      = idx_inc(head_r);
                act_slot_nxt  = head_slot;
                xfer_busy_nxt = 1'b1;
                sent_nxt      = '0;
                rcvd_nxt      = '0;
                byte_raddr    = byte_addr(head_slot, '0);
                st_nxt        = FSM_START;
              end else if (xfer_busy_r && sent_r < act_len_r) begin
                st_nxt = FSM_SEND;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            ACT_RECV: begin
              if (!xfer_busy_r) begin
                out_valid_nxt  = 1'b1;
                out_nxt.status = STAT_RX_IDLE;
              end else begin
                if (rcvd_r < act_len_r) begin
                  byte_we    = 1'b1;
                  byte_waddr = byte_addr(act_slot_r, rcvd_r[POS_W-1:0]);
                  rcvd_inc   = rcvd_r + CNT_W'(1);
                end
                rcvd_nxt = rcvd_inc;
                if (rcvd_inc >= act_len_r) begin
                  xfer_busy_nxt = 1'b0;
                  if (act_reply_r) begin
                    rpl_cnt_nxt  = '0;
                    rpl_pend_nxt = 1'b0;
                    st_nxt       = FSM_REPLY;
                  end else begin
                    out_valid_nxt         = 1'b1;
                    out_nxt.release_valid = 1'b1;
                    out_nxt.select_chip   = act_chip_r;
                  end
                end else begin
                  out_valid_nxt = 1'b1;
                end
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      FSM_START: begin
        act_len_nxt          = CNT_W'(info_rd_r.len_m1) + CNT_W'(1);
        act_chip_nxt         = info_rd_r.chip;
        act_reply_nxt        = info_rd_r.reply;
        sent_nxt             = CNT_W'(1);
        out_valid_nxt        = 1'b1;
        out_nxt.select_valid = 1'b1;
        out_nxt.select_chip  = info_rd_r.chip;
        out_nxt.send_valid   = 1'b1;
        out_nxt.send_byte    = byte_rd_r;
        st_nxt               = FSM_IDLE;
      end
      FSM_SEND: begin
        sent_nxt           = sent_r + CNT_W'(1);
        out_valid_nxt      = 1'b1;
        out_nxt.send_valid = 1'b1;
        out_nxt.send_byte  = byte_rd_r;
        st_nxt             = FSM_IDLE;
      end
      FSM_REPLY: begin
        rpl_pend_nxt = 1'b0;
        if (rpl_cnt_r < act_len_r) begin
          byte_raddr   = byte_addr(act_slot_r, rpl_cnt_r[POS_W-1:0]);
          rpl_cnt_nxt  = rpl_cnt_r + CNT_W'(1);
          rpl_pend_nxt = 1'b1;
        end
        if (rpl_pend_r) begin
          out_valid_nxt       = 1'b1;
          out_nxt.reply_valid = 1'b1;
          out_nxt.reply_byte  = byte_rd_r;
          if (rpl_cnt_r == CNT_W'(1)) begin
            out_nxt.release_valid = 1'b1;
            out_nxt.select_chip   = act_chip_r;
          end
          if (rpl_cnt_r == act_len_r) begin
            out_nxt.reply_last = 1'b1;
            st_nxt             = FSM_IDLE;
          end
        end
      end
      default: begin
        st_nxt = FSM_IDLE;
      end
    endcase
  end

  a_wait_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wait_cnt <= IDX_W'(QUEUE_LEN - 2))
    else $error("queue holds more transfers than allowed");

  a_rcvd_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (xfer_busy_r && st_r != FSM_START) |-> rcvd_r < act_len_r)
    else $error("active transfer received past its length");

  a_send_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == FSM_SEND) |-> (xfer_busy_r && sent_r < act_len_r))
    else $error("send issued without a pending byte");

  a_word_answered: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (out_valid_r || busy))
    else $error("accepted word produced no result and no work");

  a_reply_out: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == FSM_REPLY && rpl_pend_r) |=> (out_valid_r && out_word_r.reply_valid))
    else $error("reply byte read but not delivered");

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SPI transfer queue testbench
// Drives load, ready and receive command words into the queue and predicts
// every result word: status, select, sent byte, release and reply runs.
// Directed tests hit idle events, a single-byte reply and a full queue;
// random traffic then runs mostly well-formed transfers with some noise.
// ----------------------------------------------------------------------------
module tb;
  import stq_pkg::*;

  localparam action_t ACT_UNUSED   = action_t'(2'd3);
  localparam int      RING_SPAN    = 2 * QUEUE_LEN;
  localparam int      STALL_LIMIT  = 1000;
  localparam int      RANDOM_WORDS = 120;
  localparam int      MAX_REPORTS  = 10;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_word_t  in_word;
  logic      out_valid;
  out_word_t out_word;

  spi_transfer_queue dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

  logic [7:0] slot_bytes [DEPTH];
  int         slot_len   [QUEUE_LEN];
  logic [1:0] slot_chip  [QUEUE_LEN];
  logic       slot_reply [QUEUE_LEN];
  int         rd_ptr;
  int         wr_ptr;
  int         cur_slot;
  int         tx_count;
  int         rx_count;
  int         fill_count;
  logic       xfer_active;
  stat_t      fill_fault;
  out_word_t  expected_words [$];

  int mismatch_count = 0;
  int idle_cycles;
  int burst_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic in_word_t make_word(input action_t a, input logic [1:0] c,
                                         input logic [7:0] d, input logic l,
                                         input logic r);
    in_word_t w;
    w.action     = a;
    w.chip       = c;
    w.data_byte  = d;
    w.last       = l;
    w.want_reply = r;
    return w;
  endfunction

  task automatic predict_queue_response(input in_word_t w);
    out_word_t r;
    int        nwait;
    int        len;
    int        chip;
    r     = '0;
    chip  = int'(w.chip) % CHIPS;
    nwait = (wr_ptr + RING_SPAN - rd_ptr) % RING_SPAN;
    case (w.action)
      ACT_LOAD: begin
        if (fill_count == 0 && fill_fault == STAT_OK && nwait >= QUEUE_LEN - 2) begin
          fill_fault = STAT_FULL;
        end
        if (fill_fault == STAT_OK) begin
          if (fill_count >= DATA_LEN) begin
            fill_fault = STAT_LONG;
          end else begin
            slot_bytes[(wr_ptr % QUEUE_LEN) * DATA_LEN + fill_count] = w.data_byte;
            fill_count++;
          end
        end
        r.status = fill_fault;
        if (w.last) begin
          if (fill_fault == STAT_OK) begin
            slot_len[wr_ptr % QUEUE_LEN]   = fill_count;
            slot_chip[wr_ptr % QUEUE_LEN]  = 2'(chip);
            slot_reply[wr_ptr % QUEUE_LEN] = w.want_reply;
            wr_ptr = (wr_ptr + 1) % RING_SPAN;
          end
          fill_count = 0;
          fill_fault = STAT_OK;
        end
        expected_words.push_back(r);
      end
      ACT_READY: begin
        if (!xfer_active && nwait > 0) begin
          cur_slot       = rd_ptr % QUEUE_LEN;
          rd_ptr         = (rd_ptr + 1) % RING_SPAN;
          xfer_active    = 1'b1;
          tx_count       = 0;
          rx_count       = 0;
          r.select_valid = 1'b1;
          r.select_chip  = slot_chip[cur_slot];
        end
        if (xfer_active && tx_count < slot_len[cur_slot]) begin
          r.send_valid = 1'b1;
          r.send_byte  = slot_bytes[cur_slot * DATA_LEN + tx_count];
          tx_count++;
        end
        expected_words.push_back(r);
      end
      ACT_RECV: begin
        if (!xfer_active) begin
          r.status = STAT_RX_IDLE;
          expected_words.push_back(r);
        end else begin
          len = slot_len[cur_slot];
          if (rx_count < len) begin
            slot_bytes[cur_slot * DATA_LEN + rx_count] = w.data_byte;
            rx_count++;
          end
          if (rx_count >= len) begin
            xfer_active     = 1'b0;
            r.select_chip   = slot_chip[cur_slot];
            r.release_valid = 1'b1;
          end
          if (rx_count >= len && slot_reply[cur_slot]) begin
            for (int k = 0; k < len; k++) begin
              if (k > 0) begin
                r = '0;
              end
              r.reply_valid = 1'b1;
              r.reply_byte  = slot_bytes[cur_slot * DATA_LEN + k];
              r.reply_last  = (k == len - 1);
              expected_words.push_back(r);
            end
          end else begin
            expected_words.push_back(r);
          end
        end
      end
      default: begin
        expected_words.push_back(r);
      end
    endcase
  endtask

  task automatic report_mismatch(input string what, input out_word_t want,
                                 input out_word_t got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("%0t: %s: expected %h, got %h", $time, what, want, got);
    end
  endtask

  task automatic check_result(input out_word_t got);
    out_word_t want;
    logic      bad;
    if (expected_words.size() == 0) begin
      report_mismatch("result word with nothing expected", '0, got);
      return;
    end
    want = expected_words.pop_front();
    bad  = (got.status !== want.status) ||
           (got.select_valid !== want.select_valid) ||
           (got.select_chip !== want.select_chip) ||
           (got.send_valid !== want.send_valid) ||
           (got.send_byte !== want.send_byte) ||
           (got.release_valid !== want.release_valid) ||
           (got.reply_valid !== want.reply_valid) ||
           (got.reply_byte !== want.reply_byte) ||
           (got.reply_last !== want.reply_last);
    if (bad) begin
      report_mismatch("result word mismatch", want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      check_result(out_word);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_word(input in_word_t w);
    @(negedge clk);
    start   = 1'b1;
    in_word = w;
    @(posedge clk);
    while (busy) begin
      @(posedge clk);
    end
    predict_queue_response(w);
  endtask

  task automatic pause_sender(input int n);
    @(negedge clk);
    start = 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic sender_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst_left > 0) begin
      burst_left--;
    end else if (r < 6) begin
      burst_left = $urandom_range(10, 30);
    end else if (r >= 50 && r < 90) begin
      pause_sender($urandom_range(1, 3));
    end else if (r >= 90) begin
      pause_sender($urandom_range(8, 30));
    end
  endtask

  function automatic int pick_length(input int plan_no);
    int r;
    r = $urandom_range(0, 99);
    if (plan_no == 0) begin
      return DATA_LEN + 1;
    end
    if (plan_no == 1 || r < 10) begin
      return DATA_LEN;
    end
    if (r < 18) begin
      return DATA_LEN + 1 + $urandom_range(0, 1);
    end
    return $urandom_range(1, 4);
  endfunction

  task automatic test_idle_events();
    send_word(make_word(ACT_READY, 2'd0, 8'h00, 1'b0, 1'b0));
    send_word(make_word(ACT_RECV, 2'd3, 8'hFF, 1'b1, 1'b1));
    send_word(make_word(ACT_UNUSED, 2'd3, 8'hFF, 1'b1, 1'b1));
  endtask

  task automatic test_single_byte_reply();
    send_word(make_word(ACT_LOAD, 2'd3, 8'hFF, 1'b1, 1'b1));
    send_word(make_word(ACT_READY, 2'd0, 8'h00, 1'b0, 1'b0));
    send_word(make_word(ACT_READY, 2'd0, 8'h00, 1'b0, 1'b0));
    send_word(make_word(ACT_RECV, 2'd0, 8'h00, 1'b0, 1'b0));
  endtask

  task automatic test_queue_full();
    for (int i = 0; i < QUEUE_LEN - 2; i++) begin
      send_word(make_word(ACT_LOAD, 2'(i), i[0] ? 8'hA5 : 8'h5A, 1'b1, i[0]));
    end
    // refuse a whole two-byte transfer
    send_word(make_word(ACT_LOAD, 2'd1, 8'h3C, 1'b0, 1'b1));
    send_word(make_word(ACT_LOAD, 2'd2, 8'hC3, 1'b1, 1'b1));
    for (int i = 0; i < QUEUE_LEN - 2; i++) begin
      send_word(make_word(ACT_READY, 2'd0, 8'h00, 1'b0, 1'b0));
      send_word(make_word(ACT_RECV, 2'd0, 8'(8'h81 + i), 1'b0, 1'b0));
    end
  endtask

  task automatic test_random_traffic();
    int       sent;
    int       plan_left;
    int       plan_no;
    int       r;
    int       nwait;
    in_word_t w;
    sent      = 0;
    plan_left = 0;
    plan_no   = 0;
    while (sent < RANDOM_WORDS) begin
      r     = $urandom_range(0, 99);
      nwait = (wr_ptr + RING_SPAN - rd_ptr) % RING_SPAN;
      w     = make_word(ACT_LOAD, 2'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
      if (r < 8) begin
        w.action = action_t'(2'($urandom_range(0, 3)));
        if (w.action == ACT_LOAD && w.last) begin
          plan_left = 0;
        end
      end else if (plan_left > 0) begin
        w.last = (plan_left == 1);
        plan_left--;
      end else if ((xfer_active && r < 18) || (!xfer_active && nwait > 0 && r < 28) ||
                   (!xfer_active && nwait == 0)) begin
        plan_left = pick_length(plan_no);
        plan_no++;
        continue;
      end else if (xfer_active && tx_count < slot_len[cur_slot] && r < 70) begin
        w.action = ACT_READY;
      end else if (xfer_active) begin
        w.action = ACT_RECV;
      end else begin
        w.action = ACT_READY;
      end
      sender_gap();
      send_word(w);
      if (w.action != ACT_UNUSED) begin
        sent++;
      end
    end
  endtask

  initial begin
    start          = 1'b0;
    in_word        = '0;
    rst_n          = 1'b0;
    rd_ptr         = 0;
    wr_ptr         = 0;
    cur_slot       = 0;
    tx_count       = 0;
    rx_count       = 0;
    fill_count     = 0;
    xfer_active    = 1'b0;
    fill_fault     = STAT_OK;
    burst_left     = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_idle_events();
    test_single_byte_reply();
    test_queue_full();
    test_random_traffic();
    @(negedge clk);
    start = 1'b0;
    while (expected_words.size() != 0) begin
      @(posedge clk);
    end
    repeat (DATA_LEN + 8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
